/* hw/rtl/mcas_pkg.sv */
`default_nettype none
package mcas_pkg;

    localparam int DEF_SIZE = 32;
    localparam int POT_W    = 40;

    localparam logic signed [POT_W-1:0] POT_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [POT_W-1:0] POT_MIN = 40'sh80_0000_0000;

    // Controller states double as datapath operation codes.
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_IDLE   = 5'd0;
    localparam logic [OP_W-1:0] OP_DIMS   = 5'd1;
    localparam logic [OP_W-1:0] OP_CLR    = 5'd2;
    localparam logic [OP_W-1:0] OP_ARINIT = 5'd3;
    localparam logic [OP_W-1:0] OP_ARSET  = 5'd4;
    localparam logic [OP_W-1:0] OP_MRD    = 5'd5;
    localparam logic [OP_W-1:0] OP_MR0    = 5'd6;
    localparam logic [OP_W-1:0] OP_MU     = 5'd7;
    localparam logic [OP_W-1:0] OP_SRD    = 5'd8;
    localparam logic [OP_W-1:0] OP_SC1    = 5'd9;
    localparam logic [OP_W-1:0] OP_SC2    = 5'd10;
    localparam logic [OP_W-1:0] OP_SEND   = 5'd11;
    localparam logic [OP_W-1:0] OP_URD    = 5'd12;
    localparam logic [OP_W-1:0] OP_UA     = 5'd13;
    localparam logic [OP_W-1:0] OP_UB     = 5'd14;
    localparam logic [OP_W-1:0] OP_UEND   = 5'd15;
    localparam logic [OP_W-1:0] OP_MCHK   = 5'd16;
    localparam logic [OP_W-1:0] OP_AST    = 5'd17;
    localparam logic [OP_W-1:0] OP_ARD    = 5'd18;
    localparam logic [OP_W-1:0] OP_AB     = 5'd19;
    localparam logic [OP_W-1:0] OP_AO     = 5'd20;
    localparam logic [OP_W-1:0] OP_NROW   = 5'd21;
    localparam logic [OP_W-1:0] OP_TOT    = 5'd22;
    localparam logic [OP_W-1:0] OP_TOT2   = 5'd23;
    localparam logic [OP_W-1:0] OP_ORD    = 5'd24;
    localparam logic [OP_W-1:0] OP_OLD    = 5'd25;
    localparam logic [OP_W-1:0] OP_ERR    = 5'd26;
    localparam logic [OP_W-1:0] OP_OUTW   = 5'd27;

    // Configuration register indexes
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            accept;
        logic            j_clr;
        logic            j_inc;
        logic            g_clr;
        logic            g_inc;
        logic            k_clr;
        logic            k_inc;
    } mcas_cmd_t;

    typedef struct packed {
        logic dims_err;
        logic j_is_m;
        logic vis_j;
        logic guard_over;
        logic r0_bad;
        logic o_ok;
        logic j1_valid;
        logic first_found;
        logic owner_none;
        logic back_bad;
        logic j1_is_m;
        logic k_last;
        logic out_taken;
        logic out_last;
    } mcas_stat_t;

    function automatic logic signed [POT_W-1:0] sat40(input logic signed [POT_W+1:0] x);
        logic signed [POT_W-1:0] r;
        begin
            if (x > 42'(POT_MAX))
                r = POT_MAX;
            else if (x < 42'(POT_MIN))
                r = POT_MIN;
            else
                r = x[POT_W-1:0];
            return r;
        end
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/mcas_ctrl.sv */
`default_nettype none
module mcas_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_last,
    output logic                  in_ready,
    input  mcas_pkg::mcas_stat_t  stat,
    output mcas_pkg::mcas_cmd_t   cmd
);
    import mcas_pkg::*;

    logic [OP_W-1:0] state_reg;
    logic [OP_W-1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= OP_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.op     = state_reg;
        in_ready   = (state_reg == OP_IDLE);
        cmd.accept = in_ready && in_valid;
        case (state_reg)
            OP_IDLE:
                if (cmd.accept && in_last)
                    state_next = OP_DIMS;
            OP_DIMS:
            begin
                cmd.j_clr  = 1'b1;
                state_next = stat.dims_err ? OP_ERR : OP_CLR;
            end
            OP_CLR:
                if (stat.j_is_m)
                begin
                    cmd.j_clr  = 1'b1;
                    cmd.k_clr  = 1'b1;
                    state_next = OP_ARINIT;
                end
                else
                    cmd.j_inc = 1'b1;
            OP_ARINIT:
                if (stat.j_is_m)
                    state_next = OP_ARSET;
                else
                    cmd.j_inc = 1'b1;
            OP_ARSET:
            begin
                cmd.g_clr  = 1'b1;
                state_next = OP_MRD;
            end
            OP_MRD:
                state_next = stat.guard_over ? OP_AST : OP_MR0;
            OP_MR0:
                if (stat.r0_bad)
                    state_next = OP_AST;
                else
                begin
                    cmd.j_clr  = 1'b1;
                    state_next = OP_MU;
                end
            OP_MU:
                state_next = OP_SRD;
            OP_SRD:
                if (stat.j_is_m)
                    state_next = OP_SEND;
                else if (stat.vis_j)
                    cmd.j_inc = 1'b1;
                else
                    state_next = OP_SC1;
            OP_SC1:
                state_next = OP_SC2;
            OP_SC2:
            begin
                cmd.j_inc  = 1'b1;
                state_next = OP_SRD;
            end
            OP_SEND:
                if (stat.j1_valid || stat.first_found)
                begin
                    cmd.j_clr  = 1'b1;
                    state_next = OP_URD;
                end
                else
                    state_next = OP_NROW;
            OP_URD:
                state_next = OP_UA;
            OP_UA:
                if (stat.vis_j && stat.o_ok)
                    state_next = OP_UB;
                else if (stat.j_is_m)
                    state_next = OP_UEND;
                else
                begin
                    cmd.j_inc  = 1'b1;
                    state_next = OP_URD;
                end
            OP_UB:
                if (stat.j_is_m)
                    state_next = OP_UEND;
                else
                begin
                    cmd.j_inc  = 1'b1;
                    state_next = OP_URD;
                end
            OP_UEND:
            begin
                cmd.g_inc  = 1'b1;
                state_next = OP_MCHK;
            end
            OP_MCHK:
                state_next = stat.owner_none ? OP_AST : OP_MRD;
            OP_AST:
            begin
                cmd.g_clr  = 1'b1;
                state_next = OP_ARD;
            end
            OP_ARD:
                state_next = stat.guard_over ? OP_NROW : OP_AB;
            OP_AB:
                state_next = stat.back_bad ? OP_NROW : OP_AO;
            OP_AO:
            begin
                cmd.g_inc  = 1'b1;
                state_next = stat.j1_is_m ? OP_NROW : OP_ARD;
            end
            OP_NROW:
                if (stat.k_last)
                    state_next = OP_TOT;
                else
                begin
                    cmd.k_inc  = 1'b1;
                    cmd.j_clr  = 1'b1;
                    state_next = OP_ARINIT;
                end
            OP_TOT:
                state_next = OP_TOT2;
            OP_TOT2:
            begin
                cmd.k_clr  = 1'b1;
                state_next = OP_ORD;
            end
            OP_ORD:
                state_next = OP_OLD;
            OP_OLD:
                state_next = OP_OUTW;
            OP_ERR:
                state_next = OP_OUTW;
            OP_OUTW:
                if (stat.out_taken)
                begin
                    if (stat.out_last)
                        state_next = OP_IDLE;
                    else
                    begin
                        cmd.k_inc  = 1'b1;
                        state_next = OP_ORD;
                    end
                end
            default:
                state_next = OP_IDLE;
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/mcas_dpath.sv */
`default_nettype none
module mcas_dpath #(
    parameter int SIZE = mcas_pkg::DEF_SIZE
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  mcas_pkg::mcas_cmd_t      cmd,
    output mcas_pkg::mcas_stat_t     stat,
    input  wire logic [6:0]          num_rows,
    input  wire logic [6:0]          num_cols,
    input  wire logic [5:0]          in_row,
    input  wire logic [5:0]          in_col,
    input  wire logic [31:0]         in_cost,
    output logic [5:0]               out_row,
    output logic [5:0]               out_col,
    output logic [39:0]              out_total,
    output logic                     out_err,
    output logic                     out_last,
    output logic                     out_valid,
    input  wire logic                out_ready
);
    import mcas_pkg::*;

    localparam int CW = $clog2(SIZE + 1);
    localparam int TW = CW + 1;
    localparam int RW = (SIZE > 1) ? $clog2(SIZE) : 1;
    localparam int AW = (SIZE > 1) ? $clog2(SIZE * SIZE) : 1;
    localparam logic [TW-1:0] NONE = {TW{1'b1}};

    // Memories
    logic signed [31:0]       cost_mem  [SIZE*SIZE];
    logic signed [POT_W-1:0]  u_mem     [SIZE+1];
    logic signed [POT_W-1:0]  v_mem     [SIZE+1];
    logic signed [POT_W-1:0]  slack_mem [SIZE+1];
    logic [TW-1:0]            owner_mem [SIZE+1];
    logic [TW-1:0]            match_mem [SIZE+1];
    logic [CW-1:0]            back_mem  [SIZE+1];

    logic signed [31:0]       cost_rd;
    logic signed [POT_W-1:0]  u_rd;
    logic signed [POT_W-1:0]  v_rd;
    logic signed [POT_W-1:0]  slack_rd;
    logic [TW-1:0]            owner_rd;
    logic [TW-1:0]            match_rd;
    logic [CW-1:0]            back_rd;

    logic [SIZE:0]            vis_reg;
    logic [CW-1:0]            n_reg;
    logic [CW-1:0]            m_reg;
    logic [CW-1:0]            j_reg;
    logic [CW-1:0]            k_reg;
    logic [CW:0]              g_reg;
    logic [CW-1:0]            j0_reg;
    logic [CW-1:0]            j1_reg;
    logic                     j1v_reg;
    logic [TW-1:0]            r0_reg;
    logic [TW-1:0]            o_reg;
    logic signed [POT_W-1:0]  delta_reg;
    logic signed [POT_W-1:0]  ur0_reg;
    logic signed [POT_W-1:0]  cur_reg;
    logic signed [POT_W-1:0]  slk_reg;
    logic signed [POT_W-1:0]  tot_reg;

    function automatic logic [CW-1:0] clamp_dim(input logic [6:0] v);
        logic [CW-1:0] r;
        begin
            if (v == 7'd0)
                r = CW'(1);
            else if (v > 7'(SIZE))
                r = CW'(SIZE);
            else
                r = v[CW-1:0];
            return r;
        end
    endfunction

    function automatic logic [AW-1:0] cost_addr(input logic [RW-1:0] r, input logic [RW-1:0] c);
        return AW'(r) * AW'(SIZE) + AW'(c);
    endfunction

    logic [CW-1:0] rows_c;
    logic [CW-1:0] cols_c;
    logic          in_fits;
    logic [CW-1:0] first_idx;
    logic          first_found;

    assign rows_c  = clamp_dim(num_rows);
    assign cols_c  = clamp_dim(num_cols);
    assign in_fits = ({1'b0, in_row} < 7'(SIZE)) && ({1'b0, in_col} < 7'(SIZE));

    // Lowest unvisited column below the sink
    always_comb
    begin
        first_idx   = '0;
        first_found = 1'b0;
        for (int i = SIZE - 1; i >= 0; i--)
        begin
            if (!vis_reg[i] && (CW'(i) < m_reg))
            begin
                first_found = 1'b1;
                first_idx   = CW'(i);
            end
        end
    end

    // Arithmetic
    logic signed [POT_W+1:0] cur_full;
    logic signed [POT_W-1:0] slk_min;
    logic                    cur_lower;
    logic signed [POT_W-1:0] v_sub;
    logic signed [POT_W-1:0] s_sub;
    logic signed [POT_W-1:0] u_add;
    logic signed [POT_W-1:0] v_neg;
    logic                    owner_ok;

    assign cur_full  = 42'(cost_rd) - 42'(ur0_reg) - 42'(v_rd);
    assign cur_lower = cur_reg < slk_reg;
    assign slk_min   = cur_lower ? cur_reg : slk_reg;
    assign v_sub     = sat40(42'(v_rd) - 42'(delta_reg));
    assign s_sub     = sat40(42'(slack_rd) - 42'(delta_reg));
    assign u_add     = sat40(42'(u_rd) + 42'(delta_reg));
    assign v_neg     = sat40(42'sd0 - 42'(v_rd));
    assign owner_ok  = owner_rd < TW'(SIZE);

    // Read addresses
    logic [AW-1:0] cost_ra;
    logic [CW-1:0] u_ra;
    logic [CW-1:0] v_ra;
    logic [CW-1:0] owner_ra;

    always_comb
    begin
        cost_ra  = cost_addr(r0_reg[RW-1:0], j_reg[RW-1:0]);
        u_ra     = owner_rd[CW-1:0];
        v_ra     = (cmd.op == OP_TOT) ? m_reg : j_reg;
        case (cmd.op)
            OP_MRD:  owner_ra = j0_reg;
            OP_UEND: owner_ra = j1_reg;
            OP_AB:   owner_ra = back_rd;
            default: owner_ra = j_reg;
        endcase
    end

    // Write ports
    logic                     u_we;
    logic [CW-1:0]            u_wa;
    logic signed [POT_W-1:0]  u_wd;
    logic                     v_we;
    logic signed [POT_W-1:0]  v_wd;
    logic                     s_we;
    logic signed [POT_W-1:0]  s_wd;
    logic                     ow_we;
    logic [CW-1:0]            ow_wa;
    logic [TW-1:0]            ow_wd;
    logic                     mt_we;
    logic [CW-1:0]            mt_wa;
    logic [TW-1:0]            mt_wd;
    logic                     bk_we;
    logic [CW-1:0]            bk_wd;

    always_comb
    begin
        u_we  = 1'b0;  u_wa  = j_reg;  u_wd  = '0;
        v_we  = 1'b0;  v_wd  = '0;
        s_we  = 1'b0;  s_wd  = POT_MAX;
        ow_we = 1'b0;  ow_wa = j_reg;  ow_wd = NONE;
        mt_we = 1'b0;  mt_wa = j_reg;  mt_wd = NONE;
        bk_we = 1'b0;  bk_wd = m_reg;
        case (cmd.op)
            OP_CLR:
            begin
                u_we  = 1'b1;
                v_we  = 1'b1;
                ow_we = 1'b1;
                mt_we = 1'b1;
            end
            OP_ARINIT:
            begin
                s_we  = 1'b1;
                bk_we = 1'b1;
            end
            OP_ARSET:
            begin
                ow_we = 1'b1;
                ow_wa = m_reg;
                ow_wd = TW'(k_reg);
                mt_we = 1'b1;
                mt_wa = k_reg;
                mt_wd = TW'(m_reg);
            end
            OP_SC2:
            begin
                s_we  = cur_lower;
                s_wd  = cur_reg;
                bk_we = cur_lower;
                bk_wd = j0_reg;
            end
            OP_UA:
            begin
                v_we = vis_reg[j_reg];
                v_wd = v_sub;
                s_we = !vis_reg[j_reg];
                s_wd = s_sub;
            end
            OP_UB:
            begin
                u_we = 1'b1;
                u_wa = o_reg[CW-1:0];
                u_wd = u_add;
            end
            OP_AO:
            begin
                ow_we = 1'b1;
                ow_wa = j0_reg;
                ow_wd = owner_rd;
                mt_we = owner_ok;
                mt_wa = owner_rd[CW-1:0];
                mt_wd = TW'(j0_reg);
            end
            default:
            begin
                u_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_fits)
            cost_mem[cost_addr(in_row[RW-1:0], in_col[RW-1:0])] <= in_cost;
        if (u_we)
            u_mem[u_wa] <= u_wd;
        if (v_we)
            v_mem[j_reg] <= v_wd;
        if (s_we)
            slack_mem[j_reg] <= s_wd;
        if (ow_we)
            owner_mem[ow_wa] <= ow_wd;
        if (mt_we)
            match_mem[mt_wa] <= mt_wd;
        if (bk_we)
            back_mem[j_reg] <= bk_wd;

        cost_rd  <= cost_mem[cost_ra];
        u_rd     <= u_mem[u_ra];
        v_rd     <= v_mem[v_ra];
        slack_rd <= slack_mem[j_reg];
        owner_rd <= owner_mem[owner_ra];
        match_rd <= match_mem[k_reg];
        back_rd  <= back_mem[j0_reg];
    end

    // Loop counters and control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg     <= '0;
            k_reg     <= '0;
            g_reg     <= '0;
            j1v_reg   <= 1'b0;
            vis_reg   <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cmd.j_clr)
                j_reg <= '0;
            else if (cmd.j_inc)
                j_reg <= j_reg + CW'(1);
            if (cmd.k_clr)
                k_reg <= '0;
            else if (cmd.k_inc)
                k_reg <= k_reg + CW'(1);
            if (cmd.g_clr)
                g_reg <= '0;
            else if (cmd.g_inc)
                g_reg <= g_reg + (CW+1)'(1);

            if (cmd.op == OP_ARSET)
                vis_reg <= '0;
            else if (cmd.op == OP_MR0)
                vis_reg[j0_reg] <= 1'b1;

            if (cmd.op == OP_MR0)
                j1v_reg <= 1'b0;
            else if (cmd.op == OP_SC2 && slk_min < delta_reg)
                j1v_reg <= 1'b1;

            if (cmd.op == OP_OLD || cmd.op == OP_ERR)
                out_valid <= 1'b1;
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_DIMS:
            begin
                n_reg <= rows_c;
                m_reg <= cols_c;
            end
            OP_ARSET:
                j0_reg <= m_reg;
            OP_MR0:
            begin
                r0_reg    <= owner_rd;
                delta_reg <= POT_MAX;
            end
            OP_MU:
                ur0_reg <= u_rd;
            OP_SC1:
            begin
                cur_reg <= sat40(cur_full);
                slk_reg <= slack_rd;
            end
            OP_SC2:
                if (slk_min < delta_reg)
                begin
                    delta_reg <= slk_min;
                    j1_reg    <= j_reg;
                end
            OP_SEND:
                if (!j1v_reg)
                    j1_reg <= first_idx;
            OP_UA:
                o_reg <= owner_rd;
            OP_UEND:
                j0_reg <= j1_reg;
            OP_AB:
                j1_reg <= back_rd;
            OP_AO:
                j0_reg <= j1_reg;
            OP_TOT2:
                tot_reg <= v_neg;
            OP_OLD:
            begin
                out_row   <= 6'(k_reg);
                out_col   <= (match_rd < TW'(m_reg)) ? 6'(match_rd) : 6'd0;
                out_total <= tot_reg;
                out_err   <= 1'b0;
                out_last  <= (k_reg == n_reg - CW'(1));
            end
            OP_ERR:
            begin
                out_row   <= 6'd0;
                out_col   <= 6'd0;
                out_total <= '0;
                out_err   <= 1'b1;
                out_last  <= 1'b1;
            end
            default:
            begin
                tot_reg <= tot_reg;
            end
        endcase
    end

    always_comb
    begin
        stat.dims_err    = rows_c > cols_c;
        stat.j_is_m      = (j_reg == m_reg);
        stat.vis_j       = vis_reg[j_reg];
        stat.guard_over  = g_reg > {1'b0, m_reg};
        stat.r0_bad      = !owner_ok;
        stat.o_ok        = owner_ok;
        stat.j1_valid    = j1v_reg;
        stat.first_found = first_found;
        stat.owner_none  = (owner_rd == NONE);
        stat.back_bad    = back_rd > m_reg;
        stat.j1_is_m     = (j1_reg == m_reg);
        stat.k_last      = (k_reg == n_reg - CW'(1));
        stat.out_taken   = out_valid && out_ready;
        stat.out_last    = out_last;
    end

endmodule
`default_nettype wire

/* hw/rtl/min_cost_assignment_solver_core.sv */
// Minimum-cost assignment solver (Hungarian method with row/column potentials).
//
// Input stream (s_*): one cost entry per item, taken while s_tready is high.
//   Entries with row or col of SIZE or more are dropped. The item with tlast
//   set is stored and then starts the solve; s_tready stays low until the
//   last result of that solve has been taken.
// Output stream (m_*): one item per row, rows 0 .. num_rows-1 in order,
//   tlast on the final one. If num_rows exceeds num_cols a single item with
//   tuser (error) set and zero data is sent instead.
// Config (APB): num_rows at 0x0, num_cols at 0x4, both clamped to 1..SIZE at
//   the start of a solve. Write only while the block is idle.
// Operation: a load stores one entry per accepted item. A solve first sweeps the
//   solver state over all m+1 column slots (m = columns), then per row re-arms
//   the slacks and runs up to m+1 path steps, each scanning the columns through
//   memories with one read port each, then flips the path. Each result is held
//   in the output register until taken, for as long as the receiver holds
//   m_tready low.
// Reset: control state returns to idle; the cost store is not cleared.
`default_nettype none
module min_cost_assignment_solver_core #(
    parameter int SIZE = mcas_pkg::DEF_SIZE
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // row[5:0], col[11:6], cost[43:12]
    input  wire logic        s_tlast,   // last_entry
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // out_row[5:0], assigned_col[11:6], total_cost[51:12]
    output logic             m_tuser,   // error
    output logic             m_tlast,   // last
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mcas_pkg::*;

    logic [6:0] num_rows_reg;
    logic [6:0] num_cols_reg;

    mcas_cmd_t  cmd;
    mcas_stat_t stat;

    logic [5:0]  out_row;
    logic [5:0]  out_col;
    logic [39:0] out_total;

    assign pready = 1'b1;

    // Register file: index is paddr[2]
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= 7'd1;
            num_cols_reg <= 7'd1;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_NUM_ROWS)
                num_rows_reg <= pwdata[6:0];
            else
                num_cols_reg <= pwdata[6:0];
        end
    end

    assign prdata = (paddr[2] == REG_NUM_COLS) ? {25'd0, num_cols_reg} : {25'd0, num_rows_reg};

    mcas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mcas_dpath #(
        .SIZE (SIZE)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .num_rows  (num_rows_reg),
        .num_cols  (num_cols_reg),
        .in_row    (s_tdata[5:0]),
        .in_col    (s_tdata[11:6]),
        .in_cost   (s_tdata[43:12]),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_total (out_total),
        .out_err   (m_tuser),
        .out_last  (m_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    assign m_tdata = {4'd0, out_total, out_col, out_row};

endmodule
`default_nettype wire

/* hw/rtl/mcas_checker.sv */
`default_nettype none
module mcas_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // No loading while results are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input open while result pending");

    // Close the input after the starting entry
    a_solve_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still open after last entry");

    // Error result stands alone with zero data
    a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == 56'd0))
        else $error("malformed error result");

endmodule

bind min_cost_assignment_solver_core mcas_checker u_mcas_checker (.*);
`default_nettype wire
